[hw/rtl/gsbt_pkg.sv]
`timescale 1ns / 1ps

package gsbt_pkg;

    localparam int COORD_W    = 24;
    localparam int FRAC_BITS  = 24;
    localparam int CROSS_W    = 40;
    localparam int TILE_W     = 16;
    localparam int DELTA_W    = 25;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 8;

    localparam logic [CROSS_W-1:0] CROSS_MAX = '1;
    localparam logic [CROSS_W-1:0] T_ONE     = 40'h00_0100_0000;

    localparam logic [2:0] OC_START_BLOCKED = 3'd0;
    localparam logic [2:0] OC_HIT_WALL      = 3'd1;
    localparam logic [2:0] OC_REACHED_END   = 3'd2;
    localparam logic [2:0] OC_SEG_ENDED     = 3'd3;
    localparam logic [2:0] OC_STEP_LIMIT    = 3'd4;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [1:0] DIV_FIRST_X = 2'd0;
    localparam logic [1:0] DIV_DELTA_X = 2'd1;
    localparam logic [1:0] DIV_FIRST_Y = 2'd2;
    localparam logic [1:0] DIV_DELTA_Y = 2'd3;

    typedef struct packed {
        logic       load;
        logic       map_wr;
        logic       init;
        logic       div_start;
        logic [1:0] div_sel;
        logic       div_store;
        logic       advance;
        logic       res_latch;
        logic [2:0] res_code;
        logic       out_set;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic is_write;
        logic tile_blocked;
        logic at_end;
        logic step_limit;
        logic cross_over;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

[hw/rtl/grid_segment_block_test.sv]
`timescale 1ns / 1ps

// Segment blocking test over a square tile bitmap.
// Input stream (s_): tuser selects the request, 0 writes one tile's blocking
// bit, 1 queries a segment given by two signed Q15.8 endpoints. Writes give no
// transfer on the result stream; each query gives exactly one (m_).
// A write is latched, then written to the map. A query tests the start tile,
// then runs four serial divisions on the shared divider, then walks one tile
// per cycle through the single map read port (at most MAX_WALK_STEPS steps),
// then posts the result.
// After reset the bitmap is swept to passable, one tile a cycle over
// 2^(2*ceil(log2(TILES_PER_AXIS))) tiles (16384 by default); s_tready stays
// low until the sweep ends.
// The result is held in an output register: a new request is taken while a
// result waits; if the receiver stalls, a finished query holds until the
// waiting transfer is taken.
module grid_segment_block_test #(
    parameter int TILES_PER_AXIS = 128,
    parameter int TILE_SIZE_LOG2 = 8,
    parameter int MAX_WALK_STEPS = 512
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // tile_x[6:0], tile_y[13:7], tile_blocks[14], start_x[38:15],
    // start_y[62:39], end_x[86:63], end_y[110:87], zero[111]
    input  logic [gsbt_pkg::IN_DATA_W-1:0]   s_tdata,
    // req_type[0]
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // is_blocked[0], outcome[3:1], zero[7:4]
    output logic [gsbt_pkg::OUT_DATA_W-1:0]  m_tdata
);

    gsbt_pkg::dp_cmd_t  cmd;
    gsbt_pkg::dp_stat_t stat;

    // Sequence requests: write, start test, divisions, walk, post
    gsbt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the map, the walk registers, the divider and the result register
    gsbt_dp #(
        .TILES_PER_AXIS (TILES_PER_AXIS),
        .TILE_SIZE_LOG2 (TILE_SIZE_LOG2),
        .MAX_WALK_STEPS (MAX_WALK_STEPS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[hw/rtl/gsbt_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module gsbt_div #(
    parameter int NUM_W = 41,
    parameter int DEN_W = 25
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CW = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W:0]   diff;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

[hw/rtl/gsbt_map.sv]
`timescale 1ns / 1ps

// Tile bitmap with a clearing sweep after reset and a registered read.
module gsbt_map #(
    parameter int XW = 7
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_en,
    input  logic [2*XW-1:0] wr_addr,
    input  logic            wr_bit,
    input  logic [2*XW-1:0] rd_addr,
    output logic            rd_bit,
    output logic            clear_done
);

    localparam int AW    = 2 * XW;
    localparam int DEPTH = 1 << AW;

    logic          mem [DEPTH];
    logic [AW:0]   clr_cnt_reg;
    logic          rd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (!clr_cnt_reg[AW]) begin
            clr_cnt_reg <= clr_cnt_reg + (AW + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!clr_cnt_reg[AW]) begin
            mem[clr_cnt_reg[AW-1:0]] <= 1'b0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_bit;
        end
        rd_reg <= mem[rd_addr];
    end

    assign rd_bit     = rd_reg;
    assign clear_done = clr_cnt_reg[AW];

endmodule

[hw/rtl/gsbt_dp.sv]
`timescale 1ns / 1ps

module gsbt_dp #(
    parameter int TILES_PER_AXIS = 128,
    parameter int TILE_SIZE_LOG2 = 8,
    parameter int MAX_WALK_STEPS = 512
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [gsbt_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                               s_tuser,
    input  gsbt_pkg::dp_cmd_t                  cmd,
    output gsbt_pkg::dp_stat_t                 stat,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [gsbt_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int TILE_SHIFT = 8 + TILE_SIZE_LOG2;
    localparam int XW         = $clog2(TILES_PER_AXIS);
    localparam int NUM_W      = TILE_SHIFT + 1 + gsbt_pkg::FRAC_BITS;
    localparam int SW         = $clog2(MAX_WALK_STEPS + 1);
    localparam int TW         = gsbt_pkg::TILE_W;
    localparam int CXW        = gsbt_pkg::CROSS_W;
    localparam int DW         = gsbt_pkg::DELTA_W;
    localparam logic [TILE_SHIFT:0] UNIT = {1'b1, {TILE_SHIFT{1'b0}}};

    logic                      req_reg;
    logic [6:0]                wtx_reg;
    logic [6:0]                wty_reg;
    logic                      wblk_reg;
    logic signed [23:0]        ax_reg, ay_reg, bx_reg, by_reg;

    logic signed [TW-1:0]      wx_reg, wy_reg;
    logic [CXW-1:0]            cx_reg, cy_reg, ddx_reg, ddy_reg;
    logic [SW-1:0]             cnt_reg;
    logic [2:0]                res_reg;
    logic                      m_valid_reg;
    logic [2:0]                m_code_reg;

    logic signed [DW-1:0]      dx, dy;
    logic [DW-1:0]             adx, ady;
    logic signed [TW-1:0]      ex, ey;
    logic [TILE_SHIFT:0]       numx, numy, num_sel;
    logic [NUM_W-1:0]          div_num;
    logic [DW-1:0]             div_den;
    logic                      div_done;
    logic [NUM_W-1:0]          div_quo;
    logic [63:0]               q64;
    logic [CXW-1:0]            q_sat;
    logic                      zero_motion;

    logic                      step_x;
    logic signed [TW-1:0]      sxv, syv, nwx, nwy, rx, ry;
    logic [CXW:0]              sum_x, sum_y;
    logic                      outside;
    logic                      map_bit;
    logic                      wr_en;

    // Latch one transfer
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg  <= s_tuser;
            wtx_reg  <= s_tdata[6:0];
            wty_reg  <= s_tdata[13:7];
            wblk_reg <= s_tdata[14];
            ax_reg   <= s_tdata[38:15];
            ay_reg   <= s_tdata[62:39];
            bx_reg   <= s_tdata[86:63];
            by_reg   <= s_tdata[110:87];
        end
    end

    assign dx  = {bx_reg[23], bx_reg} - {ax_reg[23], ax_reg};
    assign dy  = {by_reg[23], by_reg} - {ay_reg[23], ay_reg};
    assign adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
    assign ady = dy[DW-1] ? DW'(-dy) : DW'(dy);
    assign ex  = TW'(bx_reg >>> TILE_SHIFT);
    assign ey  = TW'(by_reg >>> TILE_SHIFT);

    // Distance to the next grid line along the motion
    assign numx = dx[DW-1] ? {1'b0, ax_reg[TILE_SHIFT-1:0]}
                           : UNIT - {1'b0, ax_reg[TILE_SHIFT-1:0]};
    assign numy = dy[DW-1] ? {1'b0, ay_reg[TILE_SHIFT-1:0]}
                           : UNIT - {1'b0, ay_reg[TILE_SHIFT-1:0]};

    always_comb begin
        case (cmd.div_sel)
            gsbt_pkg::DIV_FIRST_X: num_sel = numx;
            gsbt_pkg::DIV_FIRST_Y: num_sel = numy;
            default:               num_sel = UNIT;
        endcase
    end

    assign div_num = {num_sel, {gsbt_pkg::FRAC_BITS{1'b0}}};
    assign div_den = cmd.div_sel[1] ? ady : adx;

    gsbt_div #(
        .NUM_W (NUM_W),
        .DEN_W (DW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign q64         = 64'(div_quo);
    assign zero_motion = cmd.div_sel[1] ? (dy == '0) : (dx == '0);
    assign q_sat       = (zero_motion || (|q64[63:CXW])) ? gsbt_pkg::CROSS_MAX
                                                        : q64[CXW-1:0];

    // Step selection: ties go to Y
    assign step_x = cx_reg < cy_reg;
    assign sxv    = dx[DW-1] ? '1 : TW'(1);
    assign syv    = dy[DW-1] ? '1 : TW'(1);
    assign nwx    = step_x ? wx_reg + sxv : wx_reg;
    assign nwy    = step_x ? wy_reg : wy_reg + syv;
    assign sum_x  = {1'b0, cx_reg} + {1'b0, ddx_reg};
    assign sum_y  = {1'b0, cy_reg} + {1'b0, ddy_reg};

    always_ff @(posedge aclk) begin
        if (cmd.init) begin
            wx_reg  <= TW'(ax_reg >>> TILE_SHIFT);
            wy_reg  <= TW'(ay_reg >>> TILE_SHIFT);
            cnt_reg <= '0;
        end else if (cmd.advance) begin
            wx_reg  <= nwx;
            wy_reg  <= nwy;
            cnt_reg <= cnt_reg + SW'(1);
            if (step_x) begin
                cx_reg <= sum_x[CXW] ? gsbt_pkg::CROSS_MAX : sum_x[CXW-1:0];
            end else begin
                cy_reg <= sum_y[CXW] ? gsbt_pkg::CROSS_MAX : sum_y[CXW-1:0];
            end
        end else if (cmd.div_store) begin
            case (cmd.div_sel)
                gsbt_pkg::DIV_FIRST_X: cx_reg  <= q_sat;
                gsbt_pkg::DIV_DELTA_X: ddx_reg <= q_sat;
                gsbt_pkg::DIV_FIRST_Y: cy_reg  <= q_sat;
                default:               ddy_reg <= q_sat;
            endcase
        end
    end

    // Read the tile that the walk stands on next cycle
    assign rx    = cmd.advance ? nwx : wx_reg;
    assign ry    = cmd.advance ? nwy : wy_reg;
    assign wr_en = cmd.map_wr && (32'(wtx_reg) < TILES_PER_AXIS)
                              && (32'(wty_reg) < TILES_PER_AXIS);

    gsbt_map #(
        .XW (XW)
    ) u_map (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (wr_en),
        .wr_addr    ({XW'(wty_reg), XW'(wtx_reg)}),
        .wr_bit     (wblk_reg),
        .rd_addr    ({ry[XW-1:0], rx[XW-1:0]}),
        .rd_bit     (map_bit),
        .clear_done (stat.clear_done)
    );

    assign outside = wx_reg[TW-1] || wy_reg[TW-1]
                  || (wx_reg >= TW'(TILES_PER_AXIS)) || (wy_reg >= TW'(TILES_PER_AXIS));

    assign stat.is_write     = req_reg == gsbt_pkg::REQ_WRITE;
    assign stat.tile_blocked = outside || map_bit;
    assign stat.at_end       = (wx_reg == ex) && (wy_reg == ey);
    assign stat.step_limit   = cnt_reg == SW'(MAX_WALK_STEPS);
    assign stat.cross_over   = (step_x ? cx_reg : cy_reg) > gsbt_pkg::T_ONE;
    assign stat.div_done     = div_done;
    assign stat.out_free     = !m_valid_reg;

    always_ff @(posedge aclk) begin
        if (cmd.res_latch) begin
            res_reg <= cmd.res_code;
        end
        if (cmd.out_set) begin
            m_code_reg <= res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_set) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_code_reg,
                       (m_code_reg == gsbt_pkg::OC_START_BLOCKED)
                    || (m_code_reg == gsbt_pkg::OC_HIT_WALL)
                    || (m_code_reg == gsbt_pkg::OC_STEP_LIMIT)};

endmodule

[hw/rtl/gsbt_ctrl.sv]
`timescale 1ns / 1ps

module gsbt_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  gsbt_pkg::dp_stat_t  stat,
    output gsbt_pkg::dp_cmd_t   cmd
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_RD0    = 4'd3;
    localparam logic [3:0] S_CHK0   = 4'd4;
    localparam logic [3:0] S_DIVST  = 4'd5;
    localparam logic [3:0] S_DIVW   = 4'd6;
    localparam logic [3:0] S_WALK   = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [1:0] sel_reg, sel_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            sel_reg   <= gsbt_pkg::DIV_FIRST_X;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb begin
        cmd         = '0;
        cmd.div_sel = sel_reg;
        s_tready    = 1'b0;
        state_next  = state_reg;
        sel_next    = sel_reg;
        case (state_reg)
            S_CLEAR: begin
                if (stat.clear_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (stat.is_write) begin
                    cmd.map_wr = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    cmd.init   = 1'b1;
                    state_next = S_RD0;
                end
            end
            S_RD0: state_next = S_CHK0;
            S_CHK0: begin
                if (stat.tile_blocked) begin
                    cmd.res_latch = 1'b1;
                    cmd.res_code  = gsbt_pkg::OC_START_BLOCKED;
                    state_next    = S_DONE;
                end else if (stat.at_end) begin
                    cmd.res_latch = 1'b1;
                    cmd.res_code  = gsbt_pkg::OC_REACHED_END;
                    state_next    = S_DONE;
                end else begin
                    sel_next   = gsbt_pkg::DIV_FIRST_X;
                    state_next = S_DIVST;
                end
            end
            S_DIVST: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVW;
            end
            S_DIVW: begin
                if (stat.div_done) begin
                    cmd.div_store = 1'b1;
                    if (sel_reg == gsbt_pkg::DIV_DELTA_Y) begin
                        state_next = S_WALK;
                    end else begin
                        sel_next   = sel_reg + 2'd1;
                        state_next = S_DIVST;
                    end
                end
            end
            S_WALK: begin
                if (stat.tile_blocked) begin
                    cmd.res_latch = 1'b1;
                    cmd.res_code  = gsbt_pkg::OC_HIT_WALL;
                    state_next    = S_DONE;
                end else if (stat.at_end) begin
                    cmd.res_latch = 1'b1;
                    cmd.res_code  = gsbt_pkg::OC_REACHED_END;
                    state_next    = S_DONE;
                end else if (stat.step_limit) begin
                    cmd.res_latch = 1'b1;
                    cmd.res_code  = gsbt_pkg::OC_STEP_LIMIT;
                    state_next    = S_DONE;
                end else if (stat.cross_over) begin
                    cmd.res_latch = 1'b1;
                    cmd.res_code  = gsbt_pkg::OC_SEG_ENDED;
                    state_next    = S_DONE;
                end else begin
                    cmd.advance = 1'b1;
                end
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.out_set = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

[tb/grid_segment_block_test_tb.sv]
`timescale 1ns / 1ps

module grid_segment_block_test_tb;

    localparam int TILES      = 128;
    localparam int TSHIFT     = 16;         // 8 fraction bits + tile size log2
    localparam int MAX_STEPS  = 512;
    localparam int N_RANDOM   = 1130;
    localparam int WATCHDOG   = 60000;      // covers the reset sweep and long stalls
    localparam int PEND_DEPTH = 16;

    // Scoreboard: own copy of the tile map, predicts each query outcome.
    class segment_scoreboard;
        bit            tile_map [TILES*TILES];
        logic [2:0]    pending_outcome [PEND_DEPTH];
        int            pend_wr;
        int            pend_rd;
        int            pend_cnt;
        int            errors;

        function new();
            foreach (tile_map[i]) tile_map[i] = 1'b0;
            foreach (pending_outcome[i]) pending_outcome[i] = 3'd0;
            pend_wr  = 0;
            pend_rd  = 0;
            pend_cnt = 0;
            errors   = 0;
        endfunction

        function automatic longint tile_of(longint raw);
            if (raw >= 0) return raw >>> TSHIFT;
            return -(((-raw) - 1) >>> TSHIFT) - 1;
        endfunction

        function automatic bit blocked_at(longint x, longint y);
            if (x < 0 || y < 0 || x >= TILES || y >= TILES) return 1'b1;
            return tile_map[y*TILES + x];
        endfunction

        function automatic logic [63:0] sat(logic [63:0] v);
            return (v > 64'(gsbt_pkg::CROSS_MAX)) ? 64'(gsbt_pkg::CROSS_MAX) : v;
        endfunction

        // First crossing and per-tile increment of one axis.
        function automatic void axis_init(longint a, longint d, longint tile,
                                          output logic [63:0] first,
                                          output logic [63:0] incr);
            longint unit, num;
            logic [63:0] ad;
            unit = longint'(1) << TSHIFT;
            if (d == 0) begin
                first = 64'(gsbt_pkg::CROSS_MAX);
                incr  = 64'(gsbt_pkg::CROSS_MAX);
                return;
            end
            ad  = (d > 0) ? d : -d;
            num = (d > 0) ? ((tile + 1) * unit - a) : (a - tile * unit);
            if (num < 0) num = 0;
            incr  = sat((64'(unit) << gsbt_pkg::FRAC_BITS) / ad);
            first = sat((64'(num) << gsbt_pkg::FRAC_BITS) / ad);
        endfunction

        function automatic logic [2:0] trace_segment(longint ax, longint ay,
                                                     longint bx, longint by);
            longint dx, dy, sx, sy, ex, ey, wx, wy;
            logic [63:0] cx, cy, ix, iy;
            int steps;
            dx = bx - ax;
            dy = by - ay;
            sx = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
            sy = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
            ex = tile_of(bx);
            ey = tile_of(by);
            wx = tile_of(ax);
            wy = tile_of(ay);
            if (blocked_at(wx, wy)) return gsbt_pkg::OC_START_BLOCKED;
            if (wx == ex && wy == ey) return gsbt_pkg::OC_REACHED_END;
            axis_init(ax, dx, wx, cx, ix);
            axis_init(ay, dy, wy, cy, iy);
            for (steps = 0; steps < MAX_STEPS; steps++) begin
                if (cx < cy) begin
                    if (cx > 64'(gsbt_pkg::T_ONE)) return gsbt_pkg::OC_SEG_ENDED;
                    wx += sx;
                    cx = sat(cx + ix);
                end else begin
                    if (cy > 64'(gsbt_pkg::T_ONE)) return gsbt_pkg::OC_SEG_ENDED;
                    wy += sy;
                    cy = sat(cy + iy);
                end
                if (blocked_at(wx, wy)) return gsbt_pkg::OC_HIT_WALL;
                if (wx == ex && wy == ey) return gsbt_pkg::OC_REACHED_END;
            end
            return gsbt_pkg::OC_STEP_LIMIT;
        endfunction

        function void note_request(logic req, logic [gsbt_pkg::IN_DATA_W-1:0] d);
            if (req == gsbt_pkg::REQ_WRITE) begin
                // 7-bit fields never reach past the map edge here
                tile_map[int'(d[13:7])*TILES + int'(d[6:0])] = d[14];
            end else begin
                pending_outcome[pend_wr] = trace_segment(
                    longint'($signed(d[38:15])), longint'($signed(d[62:39])),
                    longint'($signed(d[86:63])), longint'($signed(d[110:87])));
                pend_wr = (pend_wr + 1) % PEND_DEPTH;
                pend_cnt++;
            end
        endfunction

        function void check_result(logic [gsbt_pkg::OUT_DATA_W-1:0] d);
            logic [2:0] oc;
            logic       blk;
            if (pend_cnt == 0) begin
                $display("%0t: unexpected result transfer, expected none actual %h",
                         $time, d);
                errors++;
                return;
            end
            oc       = pending_outcome[pend_rd];
            pend_rd  = (pend_rd + 1) % PEND_DEPTH;
            pend_cnt--;
            blk = (oc == gsbt_pkg::OC_START_BLOCKED || oc == gsbt_pkg::OC_HIT_WALL
                   || oc == gsbt_pkg::OC_STEP_LIMIT);
            if (d[3:1] !== oc) begin
                $display("%0t: outcome mismatch, expected %0d actual %0d", $time, oc, d[3:1]);
                errors++;
            end
            if (d[0] !== blk) begin
                $display("%0t: is_blocked mismatch, expected %0b actual %0b",
                         $time, blk, d[0]);
                errors++;
            end
            if (d[7:4] !== 4'd0) begin
                $display("%0t: pad bits mismatch, expected 0 actual %h", $time, d[7:4]);
                errors++;
            end
        endfunction
    endclass

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [gsbt_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                            s_tuser = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [gsbt_pkg::OUT_DATA_W-1:0] m_tdata;

    segment_scoreboard tile_sb;
    int                idle_cycles = 0;
    bit                source_done = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    grid_segment_block_test u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // Present one transfer and hold it until accepted; drop valid only for a gap.
    task automatic send_request(logic req, logic [gsbt_pkg::IN_DATA_W-1:0] d);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        tile_sb.note_request(req, d);
    endtask

    task automatic send_write(int x, int y, bit blk);
        logic [gsbt_pkg::IN_DATA_W-1:0] d;
        d = gsbt_pkg::IN_DATA_W'({$urandom, $urandom, $urandom, $urandom});
        d[111]  = 1'b0;
        d[6:0]  = 7'(x);
        d[13:7] = 7'(y);
        d[14]   = blk;
        send_request(gsbt_pkg::REQ_WRITE, d);
    endtask

    task automatic send_query(int ax, int ay, int bx, int by);
        logic [gsbt_pkg::IN_DATA_W-1:0] d;
        d = gsbt_pkg::IN_DATA_W'({$urandom, $urandom, $urandom, $urandom});
        d[111]     = 1'b0;
        d[38:15]   = 24'(ax);
        d[62:39]   = 24'(ay);
        d[86:63]   = 24'(bx);
        d[110:87]  = 24'(by);
        send_request(gsbt_pkg::REQ_QUERY, d);
    endtask

    // Random coordinate in Q15.8 units: mostly in the map with a little margin, now and then anywhere.
    function automatic int map_coord();
        if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 24'hFFFFFF)) - (1 << 23);
        return int'($urandom_range(0, (TILES << TSHIFT) + 2000)) - 1000;
    endfunction

    // Receiver: stall at random, sometimes not at all.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tile_sb.check_result(m_tdata);
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            m_tready <= ($urandom_range(0, 9) < 7);
        end
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else if (aresetn && !(source_done && tile_sb.pend_cnt == 0))
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int i, k, x, y, len;
        tile_sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty map, same tile, zero length, edges, walls.
        send_query(100, 100, 100, 100);
        send_query(1000, 1000, 60000, 1200);
        send_query(256 << 8, 10 << 16, 256 << 8, 120 << 16);
        send_query(-5, 300, 300, 300);
        send_query(-(1 << 23), -(1 << 23), (1 << 23) - 1, (1 << 23) - 1);
        send_query((1 << 23) - 1, 0, -(1 << 23), 0);
        send_write(0, 0, 1'b1);
        send_query(10, 10, 100000, 100000);
        send_write(127, 127, 1'b1);
        send_query((127 << 16) + 5, (127 << 16) + 5, 0, 0);
        send_write(0, 0, 1'b0);
        send_write(5, 5, 1'b1);
        send_query(2 << 16, 2 << 16, 9 << 16, 9 << 16);     // diagonal tie, Y steps first
        send_query(9 << 16, 2 << 16, 2 << 16, 9 << 16);
        send_query(1 << 16, (5 << 16) + 100, 120 << 16, (5 << 16) + 100);
        send_query(1 << 16, 1 << 16, (1 << 16) + 3, 127 << 16); // near vertical
        send_query(300, 300, (127 << 16) + 65535, 65000);       // long walk
        send_query(70, 30000, 99000, 29000);
        send_write(5, 5, 1'b0);
        send_write(127, 127, 1'b0);

        // Random: bursts that mix wall writes and queries, the queries mostly inside the map.
        for (i = 0; i < N_RANDOM; i += len) begin
            len = $urandom_range(1, 12);
            for (k = 0; k < len; k++) begin
                if ($urandom_range(0, 99) < 35) begin
                    x = $urandom_range(0, 127);
                    y = $urandom_range(0, 127);
                    send_write(x, y, ($urandom_range(0, 3) != 0));
                end else if ($urandom_range(0, 19) == 0) begin
                    send_query(int'($urandom) >>> 8, int'($urandom) >>> 8,
                               int'($urandom) >>> 8, int'($urandom) >>> 8);
                end else begin
                    send_query(map_coord(), map_coord(), map_coord(), map_coord());
                end
            end
        end
        s_tvalid <= 1'b0;

        source_done = 1'b1;
        // Hold until every query has reported, then let the pipe drain.
        while (tile_sb.pend_cnt != 0) @(posedge aclk);
        repeat (800) @(posedge aclk);
        if (tile_sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
